// ----- rtl/core/qps_pkg.sv -----
// ----------------------------------------------------------------------------
// Phase stabiliser package
// Shared types and fixed constants for the error-ratio phase stabiliser.
// ----------------------------------------------------------------------------
package qps_pkg;

  // Fold window and adjust-loop constants, hundredths of a volt or Q0.16.
  localparam logic [13:0] VOLT_MIN      = 14'd100;
  localparam logic [13:0] VOLT_MAX      = 14'd10000;
  localparam logic [15:0] EXIT_MARGIN   = 16'd655;
  localparam logic [14:0] FIXED_STEP    = 15'd100;
  localparam logic [2:0]  FULL_STEPS    = 3'd5;
  localparam logic [15:0] START_DEFAULT = 16'd5000;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_DECISION_PERIODS  = 4'd0,
    REG_ERROR_THRESHOLD   = 4'd1,
    REG_HALF_WAVE_ONE     = 4'd2,
    REG_HALF_WAVE_TWO     = 4'd3,
    REG_START_VOLTAGE_ONE = 4'd4,
    REG_START_VOLTAGE_TWO = 4'd5,
    REG_TRIGGER_RUN_ONE   = 4'd6,
    REG_TRIGGER_RUN_TWO   = 4'd7
  } cfg_reg_e;

  // Input word: one counting period for both subspaces.
  typedef struct packed {
    logic [15:0] good_one;
    logic [15:0] bad_one;
    logic [15:0] good_two;
    logic [15:0] bad_two;
  } item_t;

  // Output word: one decision for both actuators.
  typedef struct packed {
    logic [13:0] volt_out_one;
    logic [13:0] volt_out_two;
    logic        moved_one;
    logic        moved_two;
    logic        range_fault_one;
    logic        range_fault_two;
    logic        adjusting_one;
    logic        adjusting_two;
  } result_t;

  // Per-lane configuration.
  typedef struct packed {
    logic [15:0] threshold;
    logic [13:0] half_wave;
    logic [3:0]  trigger_run;
    logic        load_start;
    logic [13:0] start_voltage;
  } lane_cfg_t;

  // Per-lane status towards the top level and the merge stage.
  typedef struct packed {
    logic busy;
    logic done;
  } lane_st_t;

  // Per-lane decision outcome.
  typedef struct packed {
    logic [13:0] volt;
    logic        moved;
    logic        fault;
    logic        adjusting;
  } lane_res_t;

endpackage

// ----- rtl/core/qber_phase_stabilizer.sv -----
// ----------------------------------------------------------------------------
// Error-ratio phase stabiliser, two subspaces
// The time from a word that closes a decision to its result is set by the 16-step
// ratio divider and the 17-step fold remainder in each lane.
// Throughput: one input word a cycle between decisions; after a closing word
// no word is taken until both lanes have handed their outcome to the output.
// Reset clears the sums, modes and counters and loads the default registers.
// ----------------------------------------------------------------------------
module qber_phase_stabilizer #(
  parameter int COUNT_BITS     = 16,
  parameter int PHI_TABLE_BITS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  qps_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output qps_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [3:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import qps_pkg::*;

  logic [7:0]  decision_periods;
  logic [15:0] error_threshold;
  logic [13:0] half_wave_one, half_wave_two;
  logic [3:0]  trigger_run_one, trigger_run_two;
  logic [8:0]  period_count;
  logic [8:0]  period_count_next;
  logic        go;
  logic        accept;
  logic        cfg_we;
  logic        take;
  lane_cfg_t   cfg_one, cfg_two;
  lane_st_t    st_one, st_two;
  lane_res_t   res_one, res_two;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = item_valid && !item_stall;
  assign item_stall = go || st_one.busy || st_two.busy;
  assign period_count_next = period_count + 9'd1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      decision_periods <= 8'd1;
      error_threshold  <= 16'd3277;
      half_wave_one    <= 14'd500;
      half_wave_two    <= 14'd500;
      trigger_run_one  <= 4'd2;
      trigger_run_two  <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DECISION_PERIODS: decision_periods <= cfg_data[7:0];
        REG_ERROR_THRESHOLD:  error_threshold  <= cfg_data;
        REG_HALF_WAVE_ONE:    half_wave_one    <= cfg_data[13:0];
        REG_HALF_WAVE_TWO:    half_wave_two    <= cfg_data[13:0];
        REG_TRIGGER_RUN_ONE:  trigger_run_one  <= cfg_data[3:0];
        REG_TRIGGER_RUN_TWO:  trigger_run_two  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Period counter; a decision is launched in the cycle after the closing word.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= 9'd1;
      go           <= 1'b0;
    end else begin
      go <= 1'b0;
      if (accept) begin
        if (period_count_next > {1'b0, decision_periods}) begin
          period_count <= 9'd1;
          go           <= 1'b1;
        end else begin
          period_count <= period_count_next;
        end
      end
    end
  end

  // Lane configuration.
  always_comb begin
    cfg_one.threshold     = error_threshold;
    cfg_one.half_wave     = half_wave_one;
    cfg_one.trigger_run   = trigger_run_one;
    cfg_one.load_start    = cfg_we && (cfg_index == REG_START_VOLTAGE_ONE);
    cfg_one.start_voltage = cfg_data[13:0];
    cfg_two.threshold     = error_threshold;
    cfg_two.half_wave     = half_wave_two;
    cfg_two.trigger_run   = trigger_run_two;
    cfg_two.load_start    = cfg_we && (cfg_index == REG_START_VOLTAGE_TWO);
    cfg_two.start_voltage = cfg_data[13:0];
  end

  qps_lane #(.COUNT_BITS(COUNT_BITS), .PHI_TABLE_BITS(PHI_TABLE_BITS)) u_lane_one (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_one),
    .acc   (accept),
    .good  (item.good_one),
    .bad   (item.bad_one),
    .start (go),
    .take  (take),
    .st    (st_one),
    .res   (res_one)
  );

  qps_lane #(.COUNT_BITS(COUNT_BITS), .PHI_TABLE_BITS(PHI_TABLE_BITS)) u_lane_two (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_two),
    .acc   (accept),
    .good  (item.good_two),
    .bad   (item.bad_two),
    .start (go),
    .take  (take),
    .st    (st_two),
    .res   (res_two)
  );

  qps_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .st_one       (st_one),
    .st_two       (st_two),
    .res_one      (res_one),
    .res_two      (res_two),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // A launched decision occupies both lanes in the following cycle.
  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    go |=> (st_one.busy && st_two.busy))
    else $error("decision launch did not start both lanes");

  // A fold failure reports a zero voltage.
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.range_fault_one) |-> (result.volt_out_one == 14'd0))
    else $error("range fault with non-zero voltage");

  // A good fold lies inside the actuator window.
  a_fold_window: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.range_fault_two) |->
      ((result.volt_out_two >= VOLT_MIN) && (result.volt_out_two <= VOLT_MAX)))
    else $error("folded voltage outside window");

endmodule

// ----- rtl/core/qps_lane.sv -----
// ----------------------------------------------------------------------------
// Phase stabiliser lane
// Accumulates one subspace's counts, forms the error ratio with a serial
// divider, looks up the phase step, runs the mode logic and folds the setpoint.
// ----------------------------------------------------------------------------
module qps_lane #(
  parameter int COUNT_BITS     = 16,
  parameter int PHI_TABLE_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  qps_pkg::lane_cfg_t cfg,
  input  logic              acc,
  input  logic [15:0]       good,
  input  logic [15:0]       bad,
  input  logic              start,
  input  logic              take,
  output qps_pkg::lane_st_t  st,
  output qps_pkg::lane_res_t res
);
  import qps_pkg::*;

  localparam int SW          = COUNT_BITS + 8;
  localparam int RW          = SW + 1;
  localparam int IN_BITS     = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam int PHI_ENTRIES = (1 << PHI_TABLE_BITS) + 1;
  localparam int IB          = PHI_TABLE_BITS + 1;

  typedef logic [16:0] phi_rom_t [PHI_ENTRIES];

  // sin^2(pi*p/2^17) in Q30 by a truncated Taylor series.
  function automatic logic [63:0] sin_sq_q30(input logic [63:0] p);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prodt;
    int n;
    x = (p * 64'd3373259426) >> 17;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (n = 1; n <= 7; n++) begin
      prodt = (term * x2) >> 30;
      // Each term divides by (2n)(2n+1).
      case (n)
        1: term = prodt / 64'd6;
        2: term = prodt / 64'd20;
        3: term = prodt / 64'd42;
        4: term = prodt / 64'd72;
        5: term = prodt / 64'd110;
        6: term = prodt / 64'd156;
        default: term = prodt / 64'd210;
      endcase
      if (n[0]) sum = sum - term;
      else sum = sum + term;
    end
    return (sum * sum) >> 30;
  endfunction

  // Largest phase p whose sin^2 stays at or below entry k's error level.
  function automatic logic [16:0] phi_entry(input int k);
    logic [63:0] e;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    int it;
    e = 64'(k) << (30 - PHI_TABLE_BITS);
    lo = 64'd0;
    hi = 64'd65536;
    for (it = 0; it < 18; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (sin_sq_q30(mid) <= e) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo[16:0];
  endfunction

  function automatic phi_rom_t build_rom();
    phi_rom_t rom;
    int k;
    for (k = 0; k < PHI_ENTRIES; k++) rom[k] = phi_entry(k);
    return rom;
  endfunction

  localparam phi_rom_t PHI_ROM = build_rom();

  typedef enum logic [2:0] {
    L_IDLE, L_DIV, L_LOOK, L_MUL, L_APPLY, L_FCHK, L_FEND, L_DONE
  } lane_state_t;

  lane_state_t       state;
  logic [SW-1:0]     sum_good, sum_bad;
  logic [RW-1:0]     rem, den;
  logic [15:0]       quo;
  logic [16:0]       dvd;
  logic [4:0]        cnt;
  logic              div_mod;
  logic              fold_low;
  logic [15:0]       ratio;
  logic [16:0]       phi;
  logic [14:0]       step_amt;
  logic [15:0]       setpoint;
  logic              mode;
  logic [3:0]        over_run;
  logic [2:0]        adjust_steps;
  logic              step_dir;
  logic [15:0]       last_ratio;
  logic              moved;
  logic [13:0]       volt;
  logic              fault;

  logic [SW:0]       add_good, add_bad;
  logic [RW-1:0]     total;
  logic [RW:0]       shifted;
  logic              ge;
  logic [RW-1:0]     rem_next;
  logic [16:0]       idx_sum;
  logic [IB-1:0]     phi_idx;
  logic [31:0]       prod;
  logic [3:0]        ov_inc;
  logic [2:0]        st_inc;
  logic              exit_ok;
  logic              dir_next;
  logic [14:0]       amt;
  logic [16:0]       sp_up;
  logic [15:0]       sp_moved;
  logic [14:0]       pspan;
  logic [16:0]       fold_n;
  logic [17:0]       low_res;
  logic signed [17:0] high_res;

  // Saturating accumulation of the masked counts.
  assign add_good = {1'b0, sum_good} + (SW + 1)'(good[IN_BITS-1:0]);
  assign add_bad  = {1'b0, sum_bad} + (SW + 1)'(bad[IN_BITS-1:0]);
  assign total    = {1'b0, sum_good} + {1'b0, sum_bad};

  // Shared restoring divider step, used for the ratio and the fold remainder.
  assign shifted  = {rem, div_mod ? dvd[16] : 1'b0};
  assign ge       = shifted >= {1'b0, den};
  assign rem_next = ge ? RW'(shifted - {1'b0, den}) : shifted[RW-1:0];

  // Rounded table index and the phase step product.
  assign idx_sum = {1'b0, ratio} + 17'(1 << (15 - PHI_TABLE_BITS));
  assign phi_idx = idx_sum[16:16-PHI_TABLE_BITS];
  assign prod    = 32'(phi) * 32'(cfg.half_wave) + 32'd32768;

  // Mode logic for the decision.
  always_comb begin
    ov_inc  = (over_run == 4'd15) ? over_run : over_run + 4'd1;
    st_inc  = (adjust_steps == 3'd7) ? adjust_steps : adjust_steps + 3'd1;
    exit_ok = (cfg.threshold >= EXIT_MARGIN) && (ratio <= cfg.threshold - EXIT_MARGIN);
    dir_next = mode ? (step_dir ^ (ratio > last_ratio)) : step_dir;
    amt = (!mode || (st_inc < FULL_STEPS)) ? step_amt : FIXED_STEP;
    sp_up = {1'b0, setpoint} + {2'b0, amt};
    if (dir_next) begin
      sp_moved = (setpoint > {1'b0, amt}) ? setpoint - {1'b0, amt} : 16'd0;
    end else begin
      sp_moved = sp_up[16] ? 16'hFFFF : sp_up[15:0];
    end
  end

  // Fold arithmetic: remainder form of the repeated add or subtract.
  assign pspan    = {cfg.half_wave, 1'b0};
  assign fold_n   = (setpoint < {2'b0, VOLT_MIN})
                  ? 17'(VOLT_MIN) - {1'b0, setpoint} + 17'(pspan) - 17'd1
                  : {1'b0, setpoint} - 17'(VOLT_MAX) + 17'(pspan) - 17'd1;
  assign low_res  = 18'd99 + 18'(pspan) - 18'(rem[14:0]);
  assign high_res = 18'sd10001 - $signed(18'(pspan)) + $signed(18'(rem[14:0]));

  // Count accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_good <= '0;
      sum_bad  <= '0;
    end else if (acc) begin
      sum_good <= add_good[SW] ? '1 : add_good[SW-1:0];
      sum_bad  <= add_bad[SW] ? '1 : add_bad[SW-1:0];
    end else if (start) begin
      sum_good <= '0;
      sum_bad  <= '0;
    end
  end

  // Decision sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= L_IDLE;
      setpoint     <= START_DEFAULT;
      mode         <= 1'b0;
      over_run     <= '0;
      adjust_steps <= '0;
      step_dir     <= 1'b0;
      last_ratio   <= '0;
    end else begin
      if (cfg.load_start) setpoint <= {2'b0, cfg.start_voltage};
      case (state)
        L_IDLE: begin
          if (start) begin
            div_mod <= 1'b0;
            if (total == '0) begin
              ratio <= 16'd0;
              state <= L_LOOK;
            end else if (total == {1'b0, sum_bad}) begin
              ratio <= 16'hFFFF;
              state <= L_LOOK;
            end else begin
              rem   <= {1'b0, sum_bad};
              den   <= total;
              quo   <= '0;
              cnt   <= 5'd16;
              state <= L_DIV;
            end
          end
        end
        L_DIV: begin
          rem <= rem_next;
          quo <= {quo[14:0], ge};
          dvd <= {dvd[15:0], 1'b0};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            if (div_mod) begin
              state <= L_FEND;
            end else begin
              ratio <= {quo[14:0], ge};
              state <= L_LOOK;
            end
          end
        end
        L_LOOK: begin
          phi   <= PHI_ROM[phi_idx];
          state <= L_MUL;
        end
        L_MUL: begin
          step_amt <= prod[30:16];
          state    <= L_APPLY;
        end
        L_APPLY: begin
          moved <= 1'b0;
          if (!mode) begin
            if (ratio <= cfg.threshold) begin
              over_run <= '0;
            end else if (ov_inc >= cfg.trigger_run) begin
              mode       <= 1'b1;
              last_ratio <= ratio;
              setpoint   <= sp_moved;
              moved      <= 1'b1;
              over_run   <= '0;
            end else begin
              over_run <= ov_inc;
            end
          end else if (exit_ok) begin
            mode         <= 1'b0;
            adjust_steps <= '0;
          end else begin
            adjust_steps <= st_inc;
            step_dir     <= dir_next;
            setpoint     <= sp_moved;
            moved        <= 1'b1;
            last_ratio   <= ratio;
          end
          state <= L_FCHK;
        end
        L_FCHK: begin
          if ((setpoint >= {2'b0, VOLT_MIN}) && (setpoint <= {2'b0, VOLT_MAX})) begin
            volt  <= setpoint[13:0];
            fault <= 1'b0;
            state <= L_DONE;
          end else if (pspan == '0) begin
            volt  <= '0;
            fault <= 1'b1;
            state <= L_DONE;
          end else begin
            fold_low <= setpoint < {2'b0, VOLT_MIN};
            div_mod  <= 1'b1;
            dvd      <= fold_n;
            rem      <= '0;
            den      <= RW'(pspan);
            cnt      <= 5'd17;
            state    <= L_DIV;
          end
        end
        L_FEND: begin
          if (fold_low) begin
            fault <= low_res > 18'(VOLT_MAX);
            volt  <= (low_res > 18'(VOLT_MAX)) ? 14'd0 : low_res[13:0];
          end else begin
            fault <= high_res < 18'sd100;
            volt  <= (high_res < 18'sd100) ? 14'd0 : high_res[13:0];
          end
          state <= L_DONE;
        end
        L_DONE: begin
          if (take) state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign st.busy       = state != L_IDLE;
  assign st.done       = state == L_DONE;
  assign res.volt      = volt;
  assign res.moved     = moved;
  assign res.fault     = fault;
  assign res.adjusting = mode;

endmodule

// ----- rtl/core/qps_merge.sv -----
// ----------------------------------------------------------------------------
// Phase stabiliser merge stage
// Joins both lanes' outcomes into one result word held in an output register.
// ----------------------------------------------------------------------------
module qps_merge (
  input  logic               clk,
  input  logic               rst,
  input  qps_pkg::lane_st_t  st_one,
  input  qps_pkg::lane_st_t  st_two,
  input  qps_pkg::lane_res_t res_one,
  input  qps_pkg::lane_res_t res_two,
  output logic               take,
  output logic               result_valid,
  input  logic               result_stall,
  output qps_pkg::result_t   result
);
  import qps_pkg::*;

  // Load when both lanes have finished and the register is free or draining.
  assign take = st_one.done && st_two.done && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.volt_out_one    <= res_one.volt;
      result.volt_out_two    <= res_two.volt;
      result.moved_one       <= res_one.moved;
      result.moved_two       <= res_two.moved;
      result.range_fault_one <= res_one.fault;
      result.range_fault_two <= res_two.fault;
      result.adjusting_one   <= res_one.adjusting;
      result.adjusting_two   <= res_two.adjusting;
    end
  end

endmodule
